// ===== design/cma_pkg.sv =====
`timescale 1ns / 1ps
package cma_pkg;

  localparam int MAX_RADIUS   = 15;
  localparam int RADIUS_W     = 4;
  localparam int SAMPLE_W     = 8;
  localparam int CNT_W        = 5;   // window count, up to 2*MAX_RADIUS+1
  localparam int SUM_W        = 13;  // up to 31 * 255
  localparam int ADDR_W       = 5;
  localparam int RAM_DEPTH    = 32;  // circular store, one spare entry
  localparam int DIV_STEPS    = 8;   // one quotient bit per cycle
  localparam int DIV_CNT_W    = 4;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 4'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DECIDE,
    S_FL_CHECK,
    S_FL_SUB,
    S_DIV
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // capture the input beat
    logic rd_flush;   // read address for flush trimming instead of oldest sample
    logic shift;      // write sample, update sum and count
    logic decide;     // set up divisor and flush distance
    logic fl_sub;     // drop one trailing sample during flush
    logic div_start;
    logic out_load;
    logic d_dec;
    logic clr;        // end of record
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
    logic emit_ok;
    logic cur_gt_want;
    logic div_done;
    logic out_free;
    logic d_zero;
  } status_t;

  function automatic logic [RADIUS_W-1:0] eff_radius(input logic [RADIUS_W-1:0] r);
    if (int'(r) > MAX_RADIUS) begin
      return RADIUS_W'(MAX_RADIUS);
    end
    return r;
  endfunction

endpackage

// ===== design/cma_ram.sv =====
`timescale 1ns / 1ps
module cma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cma_ctrl.sv =====
`timescale 1ns / 1ps
module cma_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cma_pkg::status_t sts,
  output cma_pkg::cmd_t    cmd
);
  import cma_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.last) begin
          state_next = S_FL_CHECK;
        end else if (sts.emit_ok) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FL_CHECK: begin
        cmd.rd_flush = 1'b1;
        if (sts.cur_gt_want) begin
          state_next = S_FL_SUB;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_FL_SUB: begin
        cmd.fl_sub = 1'b1;
        state_next = S_FL_CHECK;
      end
      S_DIV: begin
        if (sts.div_done && sts.out_free) begin
          cmd.out_load = 1'b1;
          if (!sts.last) begin
            state_next = S_IDLE;
          end else if (sts.d_zero) begin
            cmd.clr    = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.d_dec  = 1'b1;
            state_next = S_FL_CHECK;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/cma_dp.sv =====
`timescale 1ns / 1ps
module cma_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cma_pkg::SAMPLE_W-1:0]   sample,
  input  logic                           last,
  input  logic                           cfg_valid,
  input  logic [cma_pkg::RADIUS_W-1:0]   cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [cma_pkg::SAMPLE_W-1:0]   mean,
  output logic                           last_res,
  input  cma_pkg::cmd_t                  cmd,
  output cma_pkg::status_t               sts
);
  import cma_pkg::*;

  logic [RADIUS_W-1:0]  radius;
  logic [SUM_W-1:0]     sum;
  logic [CNT_W-1:0]     seen;
  logic [CNT_W-1:0]     cur;
  logic [ADDR_W-1:0]    wp;
  logic [SAMPLE_W-1:0]  sample_q;
  logic                 last_q;
  logic [RADIUS_W-1:0]  d;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W-1:0]     rem;
  logic [SAMPLE_W-1:0]  quot;

  logic [RADIUS_W-1:0]  r_eff;
  logic [CNT_W-1:0]     win;
  logic [CNT_W-1:0]     r_plus1;
  logic [CNT_W-1:0]     want_raw;
  logic [CNT_W-1:0]     want;
  logic [CNT_W-1:0]     seen_m1;
  logic [ADDR_W-1:0]    raddr;
  logic [SAMPLE_W-1:0]  rdata;
  logic [CNT_W:0]       trial;
  logic                 q_bit;

  assign r_eff    = eff_radius(radius);
  assign win      = {r_eff, 1'b1};
  assign r_plus1  = {1'b0, r_eff} + CNT_W'(1);
  assign want_raw = {1'b0, d} + r_plus1;
  assign want     = (want_raw > seen) ? seen : want_raw;
  assign seen_m1  = seen - CNT_W'(1);

  // oldest sample sits win back from the write pointer; flush trims store[cur-1]
  assign raddr = cmd.rd_flush ? (wp - cur) : (wp - win);

  cma_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.shift),
    .waddr(wp),
    .wdata(sample_q),
    .raddr(raddr),
    .rdata(rdata)
  );

  // restoring divide step
  assign trial = {rem, quot[SAMPLE_W-1]};
  assign q_bit = (trial >= {1'b0, cur});

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RESET;
      sum       <= '0;
      seen      <= '0;
      wp        <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.shift) begin
        wp <= wp + ADDR_W'(1);
        if (seen >= win) begin
          sum  <= sum - SUM_W'(rdata) + SUM_W'(sample_q);
          seen <= win;
        end else begin
          sum  <= sum + SUM_W'(sample_q);
          seen <= seen + CNT_W'(1);
        end
      end
      if (cmd.fl_sub) begin
        sum <= sum - SUM_W'(rdata);
      end
      if (cmd.clr) begin
        sum  <= '0;
        seen <= '0;
      end
      if (cfg_valid) begin
        radius <= cfg_data;
        sum    <= '0;
        seen   <= '0;
      end

      if (cmd.div_start) begin
        div_cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - DIV_CNT_W'(1);
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= sample;
      last_q   <= last;
    end
    if (cmd.decide) begin
      cur <= seen;
      d   <= (seen_m1 > CNT_W'(r_eff)) ? r_eff : seen_m1[RADIUS_W-1:0];
    end
    if (cmd.fl_sub) begin
      cur <= cur - CNT_W'(1);
    end
    if (cmd.d_dec) begin
      d <= d - RADIUS_W'(1);
    end
    if (cmd.div_start) begin
      rem  <= sum[SUM_W-1:SAMPLE_W];
      quot <= sum[SAMPLE_W-1:0];
    end else if (div_cnt != '0) begin
      rem  <= q_bit ? CNT_W'(trial - {1'b0, cur}) : trial[CNT_W-1:0];
      quot <= {quot[SAMPLE_W-2:0], q_bit};
    end
    if (cmd.out_load) begin
      mean     <= quot;
      last_res <= last_q && (d == '0);
    end
  end

  assign sts.last        = last_q;
  assign sts.emit_ok     = (seen >= r_plus1);
  assign sts.cur_gt_want = (cur > want);
  assign sts.div_done    = (div_cnt == '0);
  assign sts.out_free    = !out_valid || out_ready;
  assign sts.d_zero      = (d == '0);

endmodule

// ===== design/centered_moving_average_core.sv =====
`timescale 1ns / 1ps
// Centered moving average over records of unsigned 8-bit samples.
// Input stream (s_axis_*): one sample per beat, tlast marks the final
// sample of a record. Output stream (m_axis_*): one mean per result beat,
// tlast marks the final result of the record. Results lag the input by
// radius samples; the last input beat flushes the remaining results.
// Config channel (cfg_*): write radius (0..15) only while the block is
// idle; every write ends the current record without flushing it.
// Sequence: a sample that yields a result is shifted in, decide starts
// the divider (8 divide steps), and the result loads once the output
// register is free; only then is the next sample taken. One that yields
// none returns to idle after decide. On a flush each further result takes
// a check and the divider, plus check and subtract per trailing sample.
// Samples sit in a 32-entry circular RAM; the oldest sample is read back
// through its registered port to keep the running sum.
// Reset (rst, synchronous): radius returns to 1, the record is emptied
// and the output valid flag is cleared. No clearing pass is needed.
// Stalls: a result waits in the output register; the next sample is still
// accepted, and the core holds only when a new result is ready to load.
module centered_moving_average_core (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] sample
  input  logic       s_axis_tlast,   // last sample of record
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] mean
  output logic       m_axis_tlast,   // last result of record
  // radius register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);
  import cma_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // writes must come only while idle; the block does not enforce it, so accept them at once
  assign cfg_ready = 1'b1;

  cma_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  cma_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .sample   (s_axis_tdata),
    .last     (s_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .mean     (m_axis_tdata),
    .last_res (m_axis_tlast),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== bench/centered_moving_average_core_tb.sv =====
`timescale 1ns / 1ps
// Bench for the centered moving average core: a driver and a monitor run as
// clocked processes, and the main sequence feeds samples and radius writes.
module centered_moving_average_core_tb;
  import cma_pkg::*;

  localparam int IDLE_LIMIT   = 5000;  // cycles with no beat on any channel
  localparam int DRAIN_CYCLES = 40;    // settle time before a radius write
  localparam int LONG_HOLD    = 600;   // receiver hold-off, in cycles
  localparam int RAND_ITEMS   = 190;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_beat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic                last;
  } mean_beat_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // [7:0] sample
  logic       s_axis_tlast = 1'b0; // last sample of record
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // [7:0] mean
  logic       m_axis_tlast;        // last result of record
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = '0;

  centered_moving_average_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Samples waiting to go out, and the means that the core owes us.
  sample_beat_t sample_feed[$];
  mean_beat_t   mean_expect[$];
  int unsigned  samples_queued = 0;
  int unsigned  samples_taken  = 0;
  int unsigned  fail_count     = 0;

  // Shadow of the core: sample window (newest in entry 0), sum, fill, radius.
  logic [SAMPLE_W-1:0] win_samples [2*MAX_RADIUS+1];
  logic [SUM_W-1:0]    win_sum    = '0;
  logic [CNT_W-1:0]    win_count  = '0;
  logic [RADIUS_W-1:0] radius_now = RADIUS_RESET;

  // Idling controls of driver and monitor; dense_mode is shared by both.
  logic        dense_mode  = 1'b0;  // no gaps on either side
  logic        rx_hold_req = 1'b0;
  int unsigned rx_hold     = 0;
  int unsigned rx_gap      = 0;
  int unsigned tx_gap      = 0;
  int unsigned rx_next_gap;
  int unsigned idle_cycles = 0;
  mean_beat_t  seen_beat;
  sample_beat_t next_sample;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none at all in dense phases.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (dense_mode) begin
      return 0;
    end
    roll = $urandom_range(0, 19);
    if (roll < 10) begin
      return 0;
    end else if (roll < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(20, 60);
  endfunction

  // Shift one sample into the shadow window and queue the means it releases.
  // A plain sample releases the mean centered radius samples back; the last
  // sample of a record flushes every pending position, shrinking the window
  // from the old side as the centre moves toward the newest sample.
  function automatic void predict_means(input logic [SAMPLE_W-1:0] s, input logic is_last);
    int         reach;
    int         span;
    int         k;
    int         back;
    int         keep;
    int         want;
    int         run_sum;
    mean_beat_t beat;
    reach = (int'(radius_now) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_now);
    span  = 2 * reach + 1;
    // drop the oldest sample once the window is full
    if (int'(win_count) >= span) begin
      win_sum   -= SUM_W'(win_samples[span-1]);
      win_count  = CNT_W'(span - 1);
    end
    for (k = 2 * MAX_RADIUS; k > 0; k--) begin
      win_samples[k] = win_samples[k-1];
    end
    win_samples[0] = s;
    win_sum   += SUM_W'(s);
    win_count += CNT_W'(1);
    if (!is_last) begin
      if (int'(win_count) >= reach + 1) begin
        beat.mean = SAMPLE_W'(win_sum / win_count);
        beat.last = 1'b0;
        mean_expect.push_back(beat);
      end
      return;
    end
    keep    = int'(win_count);
    run_sum = int'(win_sum);
    for (back = (keep - 1 > reach) ? reach : keep - 1; back >= 0; back--) begin
      want = back + reach + 1;
      if (want > int'(win_count)) begin
        want = int'(win_count);
      end
      while (keep > want && keep > 1) begin
        keep--;
        run_sum -= int'(win_samples[keep]);
      end
      beat.mean = SAMPLE_W'(run_sum / keep);
      beat.last = (back == 0);
      mean_expect.push_back(beat);
    end
    win_sum   = '0;
    win_count = '0;
  endfunction

  task automatic queue_sample(input logic [SAMPLE_W-1:0] s, input logic is_last);
    sample_beat_t beat;
    beat.sample = s;
    beat.last   = is_last;
    sample_feed.push_back(beat);
    samples_queued++;
  endtask

  // Lean toward the extremes of the sample range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Hold until every sample went out and every mean came back, then let
  // the core finish any sample that releases no mean.
  task automatic wait_drained();
    while (samples_taken != samples_queued || mean_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the radius; the core drops any open record, so the shadow does too.
  task automatic write_radius(input logic [RADIUS_W-1:0] r);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    radius_now  = r;
    win_sum     = '0;
    win_count   = '0;
  endtask

  // Driver: offer the next queued sample when the slot is free and no gap is pending.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_means(s_axis_tdata, s_axis_tlast);
        samples_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          tx_gap        <= tx_gap - 1;
        end else if (sample_feed.size() > 0) begin
          next_sample    = sample_feed.pop_front();
          s_axis_tdata  <= next_sample.sample;
          s_axis_tlast  <= next_sample.last;
          s_axis_tvalid <= 1'b1;
          tx_gap        <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each mean beat against the oldest expectation, and
  // throttle tready with short gaps and the occasional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
      rx_hold       <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (mean_expect.size() == 0) begin
          $error("unexpected result beat: mean %0d last %0d", m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          seen_beat = mean_expect.pop_front();
          if (m_axis_tdata !== seen_beat.mean) begin
            $error("mean: expected %0d, got %0d", seen_beat.mean, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== seen_beat.last) begin
            $error("last_res: expected %0d, got %0d", seen_beat.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (rx_hold_req) begin
        rx_hold_req   <= 1'b0;
        rx_hold       <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold       <= rx_hold - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap        <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        rx_next_gap    = pick_gap();
        rx_gap        <= rx_next_gap;
        m_axis_tready <= (rx_next_gap == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: give up after too many cycles without a beat anywhere.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned nrec;
    int unsigned len;
    int unsigned r;
    int unsigned i;
    int unsigned j;
    logic        hold_done;
    logic        cut_short;
    rand_items = 0;
    hold_done  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset radius of one: full-scale steps, then a one-sample record.
    queue_sample(8'd255, 1'b0);
    queue_sample(8'd255, 1'b0);
    queue_sample(8'd0,   1'b0);
    queue_sample(8'd255, 1'b1);
    queue_sample(8'd128, 1'b1);
    wait_drained();

    // Radius zero passes samples straight through.
    write_radius(4'd0);
    queue_sample(8'd0,   1'b0);
    queue_sample(8'd255, 1'b0);
    queue_sample(8'd77,  1'b1);
    wait_drained();

    // Widest radius with a record too short to release anything early.
    write_radius(4'd15);
    queue_sample(8'd255, 1'b0);
    queue_sample(8'd0,   1'b0);
    queue_sample(8'd255, 1'b0);
    queue_sample(8'd255, 1'b1);
    wait_drained();

    // Open a record, then rewrite the radius in the middle of it.
    write_radius(4'd3);
    for (i = 0; i < 5; i++) begin
      queue_sample(SAMPLE_W'(40 * i + 3), 1'b0);
    end
    wait_drained();
    write_radius(4'd2);
    queue_sample(8'd10,  1'b0);
    queue_sample(8'd255, 1'b0);
    queue_sample(8'd1,   1'b1);
    wait_drained();

    // Random phases: a radius, a few records, then a full drain.
    while (rand_items < RAND_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       r = 0;
        1:       r = MAX_RADIUS;
        default: r = $urandom_range(0, 15);
      endcase
      write_radius(RADIUS_W'(r));
      dense_mode = ($urandom_range(0, 3) == 0);
      nrec = $urandom_range(1, 4);
      for (i = 0; i < nrec; i++) begin
        if (!hold_done && i == 0) begin
          len = 40;
        end else if ($urandom_range(0, 3) == 0) begin
          len = $urandom_range(2 * r + 2, 2 * r + 12);
        end else begin
          len = $urandom_range(1, r + 4);
        end
        // now and then leave the final record open for the next radius write
        cut_short = (i == nrec - 1) && ($urandom_range(0, 5) == 0);
        for (j = 0; j < len; j++) begin
          queue_sample(pick_sample(), (j == len - 1) && !cut_short);
        end
        rand_items += len;
      end
      if (!hold_done) begin
        // stall the receiver while the sender keeps pushing, to back up the core
        @(posedge clk);
        rx_hold_req <= 1'b1;
        hold_done    = 1'b1;
      end
      wait_drained();
    end
    dense_mode = 1'b0;

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
